### src/dws_pkg.sv
// Shared definitions for the double-ended queue with search.
// Holds command and status codes and the field widths; no dependencies.
`default_nettype none

package dws_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  // Default sizing of the queue.
  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_WORD_BITS = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

### src/deque_with_search_top.sv
// Top level of the double-ended queue with search; depends on dws_pkg.
// A command is accepted only while the sequencer is idle, so one command is handled at a time;
// a push answers from the execute state, a pop reads its entry and answers from the pop state,
// and list or search walk the entries in the walk state; a stalled result holds the sequencer.
// Reset clears the front pointer, entry count, walk index, sequencer and output valid only.
`default_nettype none

module deque_with_search_top #(
  parameter int CAPACITY  = dws_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = dws_pkg::DEF_WORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire logic [dws_pkg::CMD_W-1:0]     command,
  input  wire logic signed [dws_pkg::VALUE_W-1:0] value,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic [dws_pkg::STATUS_W-1:0]       status,
  output logic signed [dws_pkg::VALUE_W-1:0] word,
  output logic [dws_pkg::POS_W-1:0]          position,
  output logic                               found,
  output logic                               last
);
  import dws_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0]           state, state_next;
  logic [PTR_W-1:0]     front, front_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [PTR_W-1:0]     k, k_next;
  logic [CMD_W-1:0]     cmd_q;
  logic [WORD_BITS-1:0] key_q;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_en;
  logic [PTR_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr;

  logic [PTR_W-1:0]     slot_off;
  logic [PTR_W:0]       slot_sum;
  logic [PTR_W-1:0]     slot_addr;
  logic [PTR_W-1:0]     front_dec;

  logic                 out_free;
  logic                 emit;
  logic [STATUS_W-1:0]  e_status;
  logic [VALUE_W-1:0]   e_word;
  logic [POS_W-1:0]     e_pos;
  logic                 e_found;
  logic                 e_last;

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  logic [CNT_W-1:0]     kp1;
  logic                 at_end;
  logic                 hit;
  logic [VALUE_W-1:0]   rd_word;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign is_empty  = (count == '0);
  assign kp1       = CNT_W'(k) + CNT_W'(1);
  assign at_end    = (kp1 == count);
  assign hit       = (rd_data == key_q);
  assign rd_word   = VALUE_W'(signed'(rd_data));

  // Shared ring address unit: front plus an offset, wrapped at the capacity.
  assign slot_sum  = {1'b0, front} + {1'b0, slot_off};
  assign slot_addr = (slot_sum >= (PTR_W+1)'(CAPACITY)) ?
                     PTR_W'(slot_sum - (PTR_W+1)'(CAPACITY)) : PTR_W'(slot_sum);
  assign front_dec = (front == '0) ? PTR_W'(CAPACITY - 1) : front - PTR_W'(1);

  // Sequencer: decides each command and walks the store for list and search.
  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    k_next     = k;
    rd_en      = 1'b0;
    rd_addr    = front;
    wr_en      = 1'b0;
    wr_addr    = slot_addr;
    slot_off   = k;
    emit       = 1'b0;
    e_status   = STAT_OK;
    e_word     = '0;
    e_pos      = '0;
    e_found    = 1'b0;
    e_last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            slot_off = PTR_W'(count);
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (is_full) begin
                e_status = STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
                if (cmd_q == CMD_PUSH_FRONT) begin
                  wr_addr    = front_dec;
                  front_next = front_dec;
                end
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (is_empty) begin
              if (out_free) begin
                emit       = 1'b1;
                e_status   = STAT_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              rd_en      = 1'b1;
              count_next = count - CNT_W'(1);
              state_next = S_POP;
              if (cmd_q == CMD_POP_FRONT) begin
                slot_off   = PTR_W'(1);
                rd_addr    = front;
                front_next = slot_addr;
              end else begin
                slot_off = PTR_W'(count - CNT_W'(1));
                rd_addr  = slot_addr;
              end
            end
          end
          CMD_LIST, CMD_SEARCH: begin
            if (is_empty) begin
              if (out_free) begin
                emit       = 1'b1;
                e_status   = STAT_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              rd_en      = 1'b1;
              rd_addr    = front;
              k_next     = '0;
              state_next = S_WALK;
            end
          end
          default: begin
            // Unused command codes give one result with all fields zero but last set.
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_word     = rd_word;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        // The next entry is fetched in the same cycle the current one is used.
        slot_off = PTR_W'(kp1);
        if (cmd_q == CMD_LIST) begin
          if (out_free) begin
            emit   = 1'b1;
            e_word = rd_word;
            e_pos  = POS_W'(kp1);
            e_last = at_end;
            if (at_end) begin
              state_next = S_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = slot_addr;
              k_next  = PTR_W'(kp1);
            end
          end
        end else if (hit || at_end) begin
          if (out_free) begin
            emit       = 1'b1;
            e_found    = hit;
            e_pos      = hit ? POS_W'(kp1) : '0;
            state_next = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_addr;
          k_next  = PTR_W'(kp1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      k     <= k_next;
    end
  end

  // Command transaction capture; the value is reduced to the stored width.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      key_q <= WORD_BITS'(value);
    end
  end

  // Ring store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status   <= e_status;
      word     <= e_word;
      position <= e_pos;
      found    <= e_found;
      last     <= e_last;
    end
  end

  // The entry count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> !(res_valid && res_stall))
    else $error("result loaded over a stalled result");

  // A walk only runs over a non-empty queue.
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (count != '0) && (CNT_W'(k) < count))
    else $error("walk index outside the queue");

  // A push that is not full grows the queue by one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && emit && wr_en) |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not grow the queue");

endmodule

`default_nettype wire
